// ----- design/hsc_pkg.sv -----
// Shared types, constants and bit-mapping functions for the Hamming SEC codec.
// No dependencies; imported by every module of the codec.

package hsc_pkg;

    // Field widths of the data path.
    localparam int WORD_W = 63;
    localparam int SYN_W = 6;
    localparam int KCFG_W = 6;

    // Default and reset value for the number of data bits per block.
    localparam int MAX_DATA_BITS_DEF = 57;
    localparam int DATA_BITS_RESET = 57;

    // Request codes carried on req_type.
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Active block geometry: data bits k and code length n.
    typedef struct packed {
        logic [KCFG_W-1:0] k_bits;
        logic [SYN_W-1:0]  code_len;
    } hsc_cfg_t;

    // One finished result beat.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [SYN_W-1:0]  syndrome;
        logic              corrected;
        logic              uncorrectable;
    } hsc_result_t;

    // Code length n = k + r, with r the smallest count such that 2^r >= k + r + 1.
    function automatic logic [SYN_W-1:0] code_len(input logic [KCFG_W-1:0] k);
        logic [7:0] r;
        logic       found;
        r = '0;
        found = 1'b0;
        for (int i = 0; i <= SYN_W; i++) begin
            if (!found && ((8'd1 << i) >= (8'(k) + 8'(i) + 8'd1))) begin
                r = 8'(i);
                found = 1'b1;
            end
        end
        return SYN_W'(8'(k) + r);
    endfunction

    // Mask with the low len bits set.
    function automatic logic [WORD_W-1:0] low_mask(input logic [SYN_W-1:0] len);
        logic [WORD_W:0] m;
        m = ((WORD_W+1)'(1) << len) - (WORD_W+1)'(1);
        return m[WORD_W-1:0];
    endfunction

    // Place data bits, LSB first, at the non-power-of-two code positions.
    function automatic logic [WORD_W-1:0] spread_data(input logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] cw;
        int                d;
        cw = '0;
        d = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                cw[p-1] = data[d];
                d++;
            end
        end
        return cw;
    endfunction

    // Pull the data bits back out of the non-power-of-two code positions.
    function automatic logic [WORD_W-1:0] gather_data(input logic [WORD_W-1:0] cw);
        logic [WORD_W-1:0] data;
        int                d;
        data = '0;
        d = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                data[d] = cw[p-1];
                d++;
            end
        end
        return data;
    endfunction

    // XOR of the positions of all set bits: bit i is the parity over positions with bit i set.
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [WORD_W-1:0] w);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (w[p-1]) begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

endpackage

// ----- design/hamming_sec_codec.sv -----
// Top level of the Hamming SEC codec: input register, codec logic, result register.
// Depends on hsc_pkg, hsc_cfg and hsc_codec.
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_wr_en             cfg_wr_data (data bits per block)
//   in       in         in_valid / in_stall   req_type, word_in
//   out      out        out_valid / out_stall word_out, syndrome, corrected, uncorrectable
//
// A beat in the input register moves to the result register once that register is free,
// and its result is then offered on the out channel. The two registers form a pipeline
// that takes one beat per cycle while the result channel is not stalled.
// Reset clears both valid flags and loads 57 data bits (clamped to MAX_DATA_BITS).
// A stalled result holds; the input register keeps taking beats while it is free,
// so in_stall rises only when both registers are full and out_stall is high.

module hamming_sec_codec
    import hsc_pkg::*;
#(
    parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KCFG_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [WORD_W-1:0] word_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] word_out,
    output logic [SYN_W-1:0]  syndrome,
    output logic              corrected,
    output logic              uncorrectable
);

    hsc_cfg_t          cfg;
    hsc_result_t       result;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_req_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    hsc_result_t       out_reg;
    logic              s1_adv;
    logic              s2_adv;

    // Block-size register.
    hsc_cfg #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr_en),
        .wr_data (cfg_wr_data),
        .cfg     (cfg)
    );

    // Encode or decode the beat held in the input register.
    hsc_codec u_codec (
        .req_type (s1_req_reg),
        .word     (s1_word_reg),
        .cfg      (cfg),
        .result   (result)
    );

    // Each stage moves on when the stage after it is empty or being drained.
    always_comb
    begin
        s2_adv = !out_valid_reg || !out_stall;
        s1_adv = !s1_valid_reg || s2_adv;
        s1_valid_next = s1_adv ? in_valid : s1_valid_reg;
        out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;
    end

    assign in_stall = !s1_adv;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_adv)
        begin
            s1_req_reg <= req_type;
            s1_word_reg <= word_in;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_adv)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign word_out = out_reg.word;
    assign syndrome = out_reg.syndrome;
    assign corrected = out_reg.corrected;
    assign uncorrectable = out_reg.uncorrectable;

    // A beat in the input register always lands in the result register when it is free.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_adv |=> out_valid_reg)
        else $error("input register beat was not moved to the result register");

    // Correction and uncorrectable flags exclude each other.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(corrected && uncorrectable))
        else $error("corrected and uncorrectable both set");

    // Any flag requires a nonzero syndrome.
    a_flag_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (corrected || uncorrectable) |-> (syndrome != '0))
        else $error("error flag set with zero syndrome");

    // The block always holds at least one data bit and two parity bits.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.code_len >= SYN_W'(3)) && (cfg.k_bits != '0))
        else $error("block geometry out of range");

endmodule

// ----- design/hsc_cfg.sv -----
// Block-size register of the Hamming SEC codec: clamps the written data-bit count
// and keeps the matching code length. Depends on hsc_pkg.

module hsc_cfg
    import hsc_pkg::*;
#(
    parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [KCFG_W-1:0] wr_data,
    output hsc_cfg_t          cfg
);

    // Zero acts as one data bit, and anything above the maximum acts as the maximum.
    function automatic logic [KCFG_W-1:0] clamp_bits(input logic [KCFG_W-1:0] v);
        logic [KCFG_W-1:0] k;
        k = v;
        if (k == '0) begin
            k = KCFG_W'(1);
        end
        if (k > KCFG_W'(MAX_DATA_BITS)) begin
            k = KCFG_W'(MAX_DATA_BITS);
        end
        return k;
    endfunction

    localparam logic [KCFG_W-1:0] RESET_BITS = clamp_bits(KCFG_W'(DATA_BITS_RESET));

    logic [KCFG_W-1:0] k_bits_reg;
    logic [KCFG_W-1:0] k_bits_next;
    logic [SYN_W-1:0]  code_len_reg;
    logic [SYN_W-1:0]  code_len_next;

    // Next block geometry from the written value.
    always_comb
    begin
        k_bits_next = clamp_bits(wr_data);
        code_len_next = code_len(k_bits_next);
    end

    // Register write; the code length is derived once here, off the data path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_bits_reg <= RESET_BITS;
            code_len_reg <= code_len(RESET_BITS);
        end
        else if (wr_en)
        begin
            k_bits_reg <= k_bits_next;
            code_len_reg <= code_len_next;
        end
    end

    assign cfg.k_bits = k_bits_reg;
    assign cfg.code_len = code_len_reg;

endmodule

// ----- design/hsc_codec.sv -----
// Combinational encode and decode-and-correct logic for one beat.
// Depends on hsc_pkg for the bit-mapping and syndrome functions.

module hsc_codec
    import hsc_pkg::*;
(
    input  logic              req_type,
    input  logic [WORD_W-1:0] word,
    input  hsc_cfg_t          cfg,
    output hsc_result_t       result
);

    logic [WORD_W-1:0] enc_cw;
    logic [SYN_W-1:0]  enc_par;
    logic [WORD_W-1:0] dec_w;
    logic [WORD_W-1:0] dec_cw;
    logic [SYN_W-1:0]  dec_syn;
    logic              dec_nonzero;
    logic              dec_in_block;

    // Encode: spread the k data bits, then drop each parity bit at its power-of-two slot.
    always_comb
    begin
        enc_cw = spread_data(word & low_mask(cfg.k_bits));
        enc_par = syndrome_of(enc_cw);
        for (int i = 0; i < SYN_W; i++) begin
            enc_cw[(1 << i) - 1] = enc_par[i];
        end
    end

    // Decode: syndrome over the n code bits, flip the named bit if it lies in the block.
    always_comb
    begin
        dec_w = word & low_mask(cfg.code_len);
        dec_syn = syndrome_of(dec_w);
        dec_nonzero = (dec_syn != '0);
        dec_in_block = dec_nonzero && (dec_syn <= cfg.code_len);
        dec_cw = dec_w;
        if (dec_in_block) begin
            dec_cw = dec_w ^ (WORD_W'(1) << (dec_syn - SYN_W'(1)));
        end
    end

    // Select the result for the request type.
    always_comb
    begin
        if (req_type == REQ_DECODE)
        begin
            result.word = gather_data(dec_cw);
            result.syndrome = dec_syn;
            result.corrected = dec_in_block;
            result.uncorrectable = dec_nonzero && !dec_in_block;
        end
        else
        begin
            result.word = enc_cw;
            result.syndrome = '0;
            result.corrected = 1'b0;
            result.uncorrectable = 1'b0;
        end
    end

endmodule

// ----- tb/hsc_result_checker.sv -----
// Result checker for the Hamming SEC codec: predicts every beat from the input channel
// and compares it with the result channel. Depends on hsc_pkg for widths and codes.

module hsc_result_checker
    import hsc_pkg::*;
#(
    parameter int MAX_K = MAX_DATA_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KCFG_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              req_type,
    input  logic [WORD_W-1:0] word_in,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [WORD_W-1:0] word_out,
    input  logic [SYN_W-1:0]  syndrome,
    input  logic              corrected,
    input  logic              uncorrectable,
    output int                fail_count,
    output int                outstanding
);

    // Shadow of the data-bits register and the results still owed by the codec.
    logic [KCFG_W-1:0] k_bits_reg;
    hsc_result_t       due_results[$];

    // Computes the result of one beat for a given register value.
    function automatic hsc_result_t expected_codec_result(input logic [KCFG_W-1:0] k_raw,
                                                          input logic req,
                                                          input logic [WORD_W-1:0] w);
        hsc_result_t       res;
        logic [WORD_W-1:0] code;
        logic              par;
        int                k;
        int                r;
        int                n;
        int                d;
        int                s;
        res = '0;
        k = int'(k_raw);
        if (k < 1) k = 1;
        if (k > MAX_K) k = MAX_K;
        r = 0;
        while ((1 << r) < k + r + 1) r++;
        n = k + r;
        d = 0;
        if (req == REQ_ENCODE) begin
            // Data bits go to the positions that are not powers of two.
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    res.word[p-1] = w[d];
                    d++;
                end
            end
            // Each parity bit makes its covered positions even.
            for (int i = 0; i < r; i++) begin
                par = 1'b0;
                for (int p = 1; p <= n; p++) begin
                    if (((p >> i) & 1) != 0) par ^= res.word[p-1];
                end
                res.word[(1 << i) - 1] = par;
            end
        end
        else begin
            // Only the n bits of the block take part in decoding.
            code = '0;
            s = 0;
            for (int p = 1; p <= n; p++) begin
                code[p-1] = w[p-1];
                if (w[p-1]) s ^= p;
            end
            res.syndrome = SYN_W'(s);
            if (s != 0) begin
                if (s <= n) begin
                    code[s-1] = ~code[s-1];
                    res.corrected = 1'b1;
                end
                else begin
                    res.uncorrectable = 1'b1;
                end
            end
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    res.word[d] = code[p-1];
                    d++;
                end
            end
        end
        return res;
    endfunction

    // Check result beats against the oldest prediction, then queue new predictions.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        hsc_result_t want;
        int          errs;
        if (!rst_n)
        begin
            k_bits_reg <= KCFG_W'(DATA_BITS_RESET);
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding: word_out %h", word_out);
                    errs++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (word_out !== want.word)
                    begin
                        $error("word_out: expected %h, got %h", want.word, word_out);
                        errs++;
                    end
                    if (syndrome !== want.syndrome)
                    begin
                        $error("syndrome: expected %0d, got %0d", want.syndrome, syndrome);
                        errs++;
                    end
                    if (corrected !== want.corrected)
                    begin
                        $error("corrected: expected %b, got %b", want.corrected, corrected);
                        errs++;
                    end
                    if (uncorrectable !== want.uncorrectable)
                    begin
                        $error("uncorrectable: expected %b, got %b",
                               want.uncorrectable, uncorrectable);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(expected_codec_result(k_bits_reg, req_type, word_in));
            if (cfg_wr_en)
                k_bits_reg <= cfg_wr_data;
            fail_count <= fail_count + errs;
            outstanding <= due_results.size();
        end
    end

endmodule

// ----- tb/tb_hamming_sec_codec.sv -----
// Testbench top for the Hamming SEC codec: clock, reset, stimulus and the verdict.
// Depends on hsc_pkg, hamming_sec_codec and hsc_result_checker.

module tb_hamming_sec_codec
    import hsc_pkg::*;
();

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BEATS_PER_SETTING = 70;
    localparam int K_PLAN [12] = '{63, 0, 1, 2, 5, 11, 26, 30, 57, 12, 4, 45};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [KCFG_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              req_type = REQ_ENCODE;
    logic [WORD_W-1:0] word_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [WORD_W-1:0] word_out;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              uncorrectable;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int send_idle_pct = 35;
    int recv_stall_pct = 76;

    // Block geometry that the stimulus aims at: data bits, parity bits, code length.
    int cur_k = DATA_BITS_RESET;
    int cur_r = 6;
    int cur_n = 63;

    always #4 clk = ~clk;

    hamming_sec_codec i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .word_in       (word_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_out      (word_out),
        .syndrome      (syndrome),
        .corrected     (corrected),
        .uncorrectable (uncorrectable)
    );

    hsc_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .word_in       (word_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_out      (word_out),
        .syndrome      (syndrome),
        .corrected     (corrected),
        .uncorrectable (uncorrectable),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // The receiver stalls at random, independent of the result channel.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_hamming_sec_codec failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [WORD_W-1:0] random_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    function automatic logic [WORD_W-1:0] code_mask();
        return WORD_W'((64'd1 << cur_n) - 64'd1);
    endfunction

    // Clears the bits above the block and fixes the parity bits so the syndrome is zero.
    function automatic logic [WORD_W-1:0] clean_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] c;
        int                s;
        c = w & code_mask();
        s = 0;
        for (int p = 1; p <= cur_n; p++) begin
            if (c[p-1]) s ^= p;
        end
        for (int i = 0; i < SYN_W; i++) begin
            if (((s >> i) & 1) != 0) c[(1 << i) - 1] = ~c[(1 << i) - 1];
        end
        return c;
    endfunction

    // XORs t into the syndrome: one flipped bit inside the block, or parity flips beyond it.
    function automatic logic [WORD_W-1:0] error_word(input logic [WORD_W-1:0] c, input int t);
        if (t >= 1 && t <= cur_n)
            c[t-1] = ~c[t-1];
        else
        begin
            for (int i = 0; i < SYN_W; i++) begin
                if (((t >> i) & 1) != 0) c[(1 << i) - 1] = ~c[(1 << i) - 1];
            end
        end
        return c;
    endfunction

    // Offers one beat after a random idle gap and holds it until it is taken.
    task automatic drive_beat(input logic req, input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        word_in <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Waits until the codec is empty, then writes the data-bits register.
    task automatic set_block_k(input logic [KCFG_W-1:0] value);
        int kk;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        kk = int'(value);
        if (kk < 1) kk = 1;
        if (kk > MAX_DATA_BITS_DEF) kk = MAX_DATA_BITS_DEF;
        cur_k = kk;
        cur_r = 0;
        while ((1 << cur_r) < cur_k + cur_r + 1) cur_r++;
        cur_n = cur_k + cur_r;
    endtask

    // Mostly code words with zero, one or two errors or a syndrome beyond the block; some encodes and raw noise.
    task automatic random_beat();
        logic [WORD_W-1:0] w;
        int                pick;
        int                top_syn;
        if ($urandom_range(99) < 40)
            drive_beat(REQ_ENCODE, random_word());
        else
        begin
            w = clean_word(random_word());
            pick = $urandom_range(99);
            top_syn = (1 << cur_r) - 1;
            if (pick >= 90)
                w = random_word();
            else if (pick >= 75)
            begin
                w = error_word(w, $urandom_range(cur_n, 1));
                w = error_word(w, $urandom_range(cur_n, 1));
            end
            else if (pick >= 60 && top_syn > cur_n)
                w = error_word(w, $urandom_range(top_syn, cur_n + 1));
            else if (pick >= 15)
                w = error_word(w, $urandom_range(cur_n, 1));
            if ($urandom_range(1) == 1)
                w |= random_word() & ~code_mask();
            drive_beat(REQ_DECODE, w);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset width of 57 data bits.
        drive_beat(REQ_ENCODE, '0);
        drive_beat(REQ_ENCODE, '1);
        drive_beat(REQ_ENCODE, {6'h3F, 57'd0});
        drive_beat(REQ_ENCODE, WORD_W'(1));
        drive_beat(REQ_DECODE, '0);
        drive_beat(REQ_DECODE, '1);
        drive_beat(REQ_DECODE, clean_word(random_word()));
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 1));
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 63));
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 3));

        // Two data bits leave syndromes 6 and 7 outside the block.
        set_block_k(KCFG_W'(2));
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 6));
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 7));
        drive_beat(REQ_DECODE, ~code_mask());
        drive_beat(REQ_ENCODE, WORD_W'(3) | ~code_mask());
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 5));

        // A zero register acts as one data bit; 63 is clamped to the maximum.
        set_block_k(KCFG_W'(0));
        drive_beat(REQ_ENCODE, WORD_W'(1));
        drive_beat(REQ_DECODE, '1);
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 2));
        set_block_k(KCFG_W'(63));
        drive_beat(REQ_ENCODE, '1);
        drive_beat(REQ_DECODE, error_word(clean_word(random_word()), 62));

        // Random beats over a range of widths and three idling patterns.
        foreach (K_PLAN[j])
        begin
            if (j == 4)
            begin
                send_idle_pct = 76;
                recv_stall_pct = 35;
            end
            else if (j == 8)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            set_block_k(KCFG_W'(K_PLAN[j]));
            repeat (BEATS_PER_SETTING) random_beat();
        end

        // Drain the codec, then give the verdict.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_hamming_sec_codec passed");
        else
            $display("tb_hamming_sec_codec failed");
        $finish;
    end

endmodule
